### sv/pidc_pkg.sv
// shared types and constants for the pid controller step block
// no dependencies

package pidc_pkg;

   localparam int SIG_W  = 32;   // q16.16 signal width
   localparam int GAIN_W = 24;   // q8.16 register width
   localparam int SUM_W  = 48;   // q32.16 error sum width
   localparam int FRAC_W = 16;   // fraction bits of the gains
   localparam int DVD_W  = SUM_W + FRAC_W;
   localparam int IDX_W  = 2;

   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [IDX_W-1:0] REG_PROP_GAIN     = 2'd0;
   localparam logic [IDX_W-1:0] REG_INTEGRAL_TIME = 2'd1;
   localparam logic [IDX_W-1:0] REG_DERIV_GAIN    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_RUN,
      ST_FIN
   } state_type;

endpackage

### sv/pidc_mul.sv
// bit-serial signed shift-add multiplier, one multiplier bit per cycle
// depends on nothing

module pidc_mul #(
   parameter int AW = 24,
   parameter int BW = 33
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [AW-1:0]  mplr,
   input  logic signed [BW-1:0]  mcand,
   output logic signed [AW+BW-1:0] product
);

   localparam int PW = AW + BW;
   localparam int CW = $clog2(AW);

   logic signed [PW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] mcand_ff, mcand_in;
   logic [AW-1:0]        mplr_ff, mplr_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic signed [PW-1:0] term;

   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      mplr_in  = mplr_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      term     = mplr_ff[0] ? mcand_ff : '0;
      if (start) begin
         acc_in   = '0;
         mcand_in = PW'(mcand);
         mplr_in  = mplr;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // sign bit of the multiplier weighs negative
         if (cnt_ff == CW'(AW - 1)) begin
            acc_in  = acc_ff - term;
            busy_in = 1'b0;
         end else begin
            acc_in = acc_ff + term;
         end
         mcand_in = mcand_ff <<< 1;
         mplr_in  = mplr_ff >> 1;
         cnt_in   = cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      mplr_ff  <= mplr_in;
   end

   assign product = acc_ff;

endmodule

### sv/pidc_div.sv
// restoring divider, one quotient bit per cycle, quotient clamped to 2^48
// depends on pidc_pkg

module pidc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pidc_pkg::SUM_W-1:0]  num_mag,
   input  logic [pidc_pkg::GAIN_W-1:0] den_mag,
   output logic                        done,
   output logic [pidc_pkg::SUM_W:0]    quot
);

   localparam int DW = pidc_pkg::DVD_W;
   localparam int GW = pidc_pkg::GAIN_W;
   localparam int SW = pidc_pkg::SUM_W;
   localparam int CW = $clog2(DW);

   logic [DW-1:0] dvd_ff, dvd_in;
   logic [GW-1:0] rem_ff, rem_in;
   logic [GW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [GW:0]   trial;
   logic [GW:0]   diff;
   logic          fits;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      trial   = {rem_ff, dvd_ff[DW-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = (trial >= {1'b0, den_ff});
      if (start) begin
         dvd_in  = {num_mag, {pidc_pkg::FRAC_W{1'b0}}};
         rem_in  = '0;
         den_in  = den_mag;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[GW-1:0] : trial[GW-1:0];
         dvd_in = {dvd_ff[DW-2:0], fits};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // clamp anything above 2^48 to 2^48
   always_comb begin
      if ((|dvd_ff[DW-1:SW+1]) || (dvd_ff[SW] && (|dvd_ff[SW-1:0]))) begin
         quot = {1'b1, {SW{1'b0}}};
      end else begin
         quot = dvd_ff[SW:0];
      end
   end

   assign done = done_ff;

endmodule

### sv/pid_controller_step.sv
// top level of the fixed point pid controller step
// depends on pidc_pkg, pidc_mul and pidc_div
//
// a step item forms the saturated error, updates the 48-bit error sum
// (skipped while the integral time is zero) and then runs three bit-serial
// units side by side: two shift-add multipliers for the proportional and
// derivative terms and a restoring divider for the integral term, one
// quotient bit per cycle over the 64-bit scaled sum. the divider sets the
// pace: a step item passes through prep, run and fin, while a clear item
// goes from idle straight to fin. one item is worked at a time; req_stall
// is high while an item is in flight, and a finished result waits in the
// output register so the next item can be taken while the consumer stalls.
// configuration registers must only be written while the block is idle.

module pid_controller_step (
   input  logic                                clock,
   input  logic                                reset,
   // configuration writes
   input  logic                                csr_write_en,
   input  logic [pidc_pkg::IDX_W-1:0]          csr_index,
   input  logic [pidc_pkg::GAIN_W-1:0]         csr_wdata,
   // request items
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic signed [pidc_pkg::SIG_W-1:0]   req_setpoint,
   input  logic signed [pidc_pkg::SIG_W-1:0]   req_measured,
   // response items
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [pidc_pkg::SIG_W-1:0]   rsp_drive,
   output logic                                rsp_saturated
);

   localparam int SW  = pidc_pkg::SIG_W;
   localparam int GW  = pidc_pkg::GAIN_W;
   localparam int UW  = pidc_pkg::SUM_W;
   localparam int FW  = pidc_pkg::FRAC_W;
   localparam int DFW = SW + 1;            // error difference width
   localparam int PPW = GW + SW;           // p product width
   localparam int DPW = GW + DFW;          // d product width
   localparam int TW  = UW + 2;            // total width

   // drive limits at total width
   localparam logic signed [TW-1:0] DRV_MAX = TW'(64'sh7fff_ffff);
   localparam logic signed [TW-1:0] DRV_MIN = TW'(-64'sh8000_0000);

   // configuration registers
   logic signed [GW-1:0] kp_ff, ti_ff, kd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= '0;
         ti_ff <= '0;
         kd_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            pidc_pkg::REG_PROP_GAIN:     kp_ff <= csr_wdata;
            pidc_pkg::REG_INTEGRAL_TIME: ti_ff <= csr_wdata;
            pidc_pkg::REG_DERIV_GAIN:    kd_ff <= csr_wdata;
            default: ;                   // unused index ignored
         endcase
      end
   end

   pidc_pkg::state_type state_ff, state_in;

   logic signed [SW-1:0] err_ff, err_in;
   logic signed [SW-1:0] last_ff, last_in;
   logic signed [UW-1:0] sum_ff, sum_in;
   logic                 sat_ff, sat_in;
   logic                 clr_ff, clr_in;
   logic                 neg_ff, neg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0] rsp_drive_ff, rsp_drive_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   logic                 req_take;
   logic                 unit_start;
   logic signed [SW:0]   err_wide;
   logic signed [UW:0]   sum_wide;
   logic signed [DFW-1:0] diff;
   logic [UW-1:0]        num_mag;
   logic [GW-1:0]        den_mag;
   logic                 ti_zero;
   logic                 div_done;
   logic [UW:0]          quot;
   logic signed [PPW-1:0] p_prod;
   logic signed [DPW-1:0] d_prod;
   logic signed [TW-1:0] i_term;
   logic signed [TW-1:0] total;

   assign req_take = req_valid && !req_stall;
   assign ti_zero  = (ti_ff == '0);

   // 33-bit error before saturation
   assign err_wide = SW'(req_setpoint) - SW'(req_measured);
   assign diff     = DFW'(err_ff) - DFW'(last_ff);
   assign sum_wide = (UW + 1)'(sum_ff) + (UW + 1)'(err_ff);

   // serial units
   pidc_mul #(.AW(GW), .BW(SW)) u_mul_p (
      .clock   (clock),
      .reset   (reset),
      .start   (unit_start),
      .mplr    (kp_ff),
      .mcand   (err_ff),
      .product (p_prod)
   );

   pidc_mul #(.AW(GW), .BW(DFW)) u_mul_d (
      .clock   (clock),
      .reset   (reset),
      .start   (unit_start),
      .mplr    (kd_ff),
      .mcand   (diff),
      .product (d_prod)
   );

   pidc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (unit_start),
      .num_mag (num_mag),
      .den_mag (den_mag),
      .done    (div_done),
      .quot    (quot)
   );

   assign den_mag = ti_ff[GW-1] ? GW'(-ti_ff) : GW'(ti_ff);

   // integral and drive sum
   always_comb begin
      if (ti_zero) begin
         i_term = '0;
      end else if (neg_ff) begin
         i_term = -TW'(quot);
      end else begin
         i_term = TW'(quot);
      end
      // products floored by 2^16, sign kept
      total = TW'($signed(p_prod[PPW-1:FW])) + TW'($signed(d_prod[DPW-1:FW])) + i_term;
   end

   always_comb begin
      state_in     = state_ff;
      err_in       = err_ff;
      last_in      = last_ff;
      sum_in       = sum_ff;
      sat_in       = sat_ff;
      clr_in       = clr_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_sat_in   = rsp_sat_ff;
      unit_start   = 1'b0;
      num_mag      = '0;
      req_stall    = (state_ff != pidc_pkg::ST_IDLE);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         pidc_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_operation == pidc_pkg::OP_CLEAR) begin
                  sum_in   = '0;
                  last_in  = '0;
                  clr_in   = 1'b1;
                  state_in = pidc_pkg::ST_FIN;
               end else begin
                  // saturate the error to 32 bits
                  if (!err_wide[SW] && err_wide[SW-1]) begin
                     err_in = {1'b0, {(SW - 1){1'b1}}};
                     sat_in = 1'b1;
                  end else if (err_wide[SW] && !err_wide[SW-1]) begin
                     err_in = {1'b1, {(SW - 1){1'b0}}};
                     sat_in = 1'b1;
                  end else begin
                     err_in = err_wide[SW-1:0];
                     sat_in = 1'b0;
                  end
                  clr_in   = 1'b0;
                  state_in = pidc_pkg::ST_PREP;
               end
            end
         end
         pidc_pkg::ST_PREP: begin
            // sum update, skipped with integral disabled
            if (!ti_zero) begin
               if (sum_wide[UW] != sum_wide[UW-1]) begin
                  sum_in = sum_wide[UW] ? {1'b1, {(UW - 1){1'b0}}}
                                        : {1'b0, {(UW - 1){1'b1}}};
                  sat_in = 1'b1;
               end else begin
                  sum_in = sum_wide[UW-1:0];
               end
            end
            num_mag    = sum_in[UW-1] ? UW'(-sum_in) : UW'(sum_in);
            neg_in     = sum_in[UW-1] ^ ti_ff[GW-1];
            unit_start = 1'b1;
            last_in    = err_ff;
            state_in   = pidc_pkg::ST_RUN;
         end
         pidc_pkg::ST_RUN: begin
            // multipliers finish well before the divider
            if (div_done) begin
               state_in = pidc_pkg::ST_FIN;
            end
         end
         pidc_pkg::ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = pidc_pkg::ST_IDLE;
               if (clr_ff) begin
                  rsp_drive_in = '0;
                  rsp_sat_in   = 1'b0;
               end else if (total > DRV_MAX) begin
                  rsp_drive_in = {1'b0, {(SW - 1){1'b1}}};
                  rsp_sat_in   = 1'b1;
               end else if (total < DRV_MIN) begin
                  rsp_drive_in = {1'b1, {(SW - 1){1'b0}}};
                  rsp_sat_in   = 1'b1;
               end else begin
                  rsp_drive_in = total[SW-1:0];
                  rsp_sat_in   = sat_ff;
               end
            end
         end
         default: state_in = pidc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pidc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         last_ff      <= '0;
         clr_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         last_ff      <= last_in;
         clr_ff       <= clr_in;
      end
      err_ff       <= err_in;
      sat_ff       <= sat_in;
      neg_ff       <= neg_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = rsp_drive_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

### sv/pidc_check.sv
// port-level checks for the pid controller step, bound to the top level
// depends on pidc_pkg and pid_controller_step

module pidc_check (
   input logic                                clock,
   input logic                                reset,
   input logic                                csr_write_en,
   input logic [pidc_pkg::IDX_W-1:0]          csr_index,
   input logic [pidc_pkg::GAIN_W-1:0]         csr_wdata,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_operation,
   input logic signed [pidc_pkg::SIG_W-1:0]   req_setpoint,
   input logic signed [pidc_pkg::SIG_W-1:0]   req_measured,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [pidc_pkg::SIG_W-1:0]   rsp_drive,
   input logic                                rsp_saturated
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive) && $stable(rsp_saturated))
      else $error("stalled result changed");

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while busy");

   // a clear item into a free output yields zero by way of the fin state
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_operation == pidc_pkg::OP_CLEAR && !rsp_valid
      |=> ##1 rsp_valid && rsp_drive == '0 && !rsp_saturated)
      else $error("clear item gave wrong result");

   // nothing shows right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind pid_controller_step pidc_check u_check (.*);

### verif/pid_controller_step_tb.sv
// self-checking testbench for the fixed point pid controller step block
// depends on pidc_pkg and pid_controller_step; stands alone otherwise

`timescale 1ns / 1ps

module pid_controller_step_tb;

   typedef struct {
      logic                              op;
      logic signed [pidc_pkg::SIG_W-1:0] sp;
      logic signed [pidc_pkg::SIG_W-1:0] meas;
      logic                              known;   // expected result typed in below
      logic signed [pidc_pkg::SIG_W-1:0] drv;
      logic                              sat;
   } stim_row_type;

   typedef struct {
      logic signed [pidc_pkg::SIG_W-1:0] drv;
      logic                              sat;
   } drive_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_write_en = 1'b0;
   logic [pidc_pkg::IDX_W-1:0]          csr_index = '0;
   logic [pidc_pkg::GAIN_W-1:0]         csr_wdata = '0;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_operation = pidc_pkg::OP_STEP;
   logic signed [pidc_pkg::SIG_W-1:0]   req_setpoint = '0;
   logic signed [pidc_pkg::SIG_W-1:0]   req_measured = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [pidc_pkg::SIG_W-1:0]   rsp_drive;
   logic                                rsp_saturated;

   // predictor copy of the registers and state
   logic signed [pidc_pkg::GAIN_W-1:0] kp, ti, kd;
   logic signed [pidc_pkg::SUM_W-1:0]  err_sum;
   logic signed [pidc_pkg::SIG_W-1:0]  prev_err;

   drive_result_type pending_drives[$];
   int  fail_count = 0;
   bit  hold_rsp = 1'b0;     // long consumer hold-off request
   bit  stim_done = 1'b0;

   pid_controller_step i_dut (.*);

   always #5 clock = ~clock;

   initial begin
      #50_000_000;
      $display("pid_controller_step_tb: FAIL");
      $finish;
   end

   // floor division by 2^16 of a signed product
   function automatic longint floor_frac(input longint x);
      return x >>> pidc_pkg::FRAC_W;
   endfunction

   function automatic drive_result_type predict_drive(
         input logic op,
         input logic signed [pidc_pkg::SIG_W-1:0] sp,
         input logic signed [pidc_pkg::SIG_W-1:0] meas);
      drive_result_type r;
      longint e, p, ip, d, tot, s, num, den, q;
      bit sat;
      r.drv = '0;
      r.sat = 1'b0;
      sat = 0;
      ip = 0;
      if (op == pidc_pkg::OP_CLEAR) begin
         err_sum = '0;
         prev_err = '0;
         return r;
      end
      e = longint'(sp) - longint'(meas);
      if (e > 64'sd2147483647) begin
         e = 64'sd2147483647; sat = 1;
      end else if (e < -64'sd2147483648) begin
         e = -64'sd2147483648; sat = 1;
      end
      p = floor_frac(longint'(kp) * e);
      if (ti != 0) begin
         s = longint'(err_sum) + e;
         if (s > 64'sd140737488355327) begin
            s = 64'sd140737488355327; sat = 1;
         end else if (s < -64'sd140737488355328) begin
            s = -64'sd140737488355328; sat = 1;
         end
         err_sum = s[pidc_pkg::SUM_W-1:0];
         num = (s < 0) ? -s : s;
         den = (ti < 0) ? -longint'(ti) : longint'(ti);
         // magnitude fits 48 bits, shifted fits 64 bits unsigned
         q = longint'(64'(unsigned'(num) << pidc_pkg::FRAC_W) / unsigned'(den));
         if (unsigned'(q) > (64'd1 << 48)) q = longint'(64'd1 << 48);
         ip = ((s < 0) != (ti < 0)) ? -q : q;
      end
      d = floor_frac(longint'(kd) * (e - longint'(prev_err)));
      prev_err = e[pidc_pkg::SIG_W-1:0];
      tot = p + ip + d;
      if (tot > 64'sd2147483647) begin
         tot = 64'sd2147483647; sat = 1;
      end else if (tot < -64'sd2147483648) begin
         tot = -64'sd2147483648; sat = 1;
      end
      r.drv = tot[pidc_pkg::SIG_W-1:0];
      r.sat = sat;
      return r;
   endfunction

   task automatic write_reg(input logic [pidc_pkg::IDX_W-1:0] idx,
                            input logic [pidc_pkg::GAIN_W-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         pidc_pkg::REG_PROP_GAIN:     kp = val;
         pidc_pkg::REG_INTEGRAL_TIME: ti = val;
         pidc_pkg::REG_DERIV_GAIN:    kd = val;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      while (pending_drives.size() != 0 && guard < 200_000) begin
         @(negedge clock);
         guard++;
      end
      repeat (80) @(negedge clock);
   endtask

   // offer one item, hold it until accepted; keeps valid high between items
   task automatic send_item(input logic op, input logic signed [pidc_pkg::SIG_W-1:0] sp,
                            input logic signed [pidc_pkg::SIG_W-1:0] meas, input bit known,
                            input logic signed [pidc_pkg::SIG_W-1:0] kdrv, input logic ksat);
      drive_result_type r;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_setpoint  <= sp;
      req_measured  <= meas;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = predict_drive(op, sp, meas);
      if (known && (r.drv !== kdrv || r.sat !== ksat)) begin
         $error("directed row disagrees with predictor: drive %0d/%0d", kdrv, r.drv);
         fail_count++;
      end
      if (known) begin
         r.drv = kdrv;
         r.sat = ksat;
      end
      pending_drives.push_back(r);
      @(negedge clock);
   endtask

   task automatic idle_gap(input int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // random item, now and then a clear: mostly small errors, sometimes full range
   task automatic send_random();
      logic op;
      logic signed [pidc_pkg::SIG_W-1:0] sp, ms;
      op = ($urandom_range(0, 40) == 0) ? pidc_pkg::OP_CLEAR : pidc_pkg::OP_STEP;
      if ($urandom_range(0, 7) == 0) begin
         sp = $urandom; ms = $urandom;
      end else begin
         sp = $signed($urandom_range(0, 2_000_000)) - 1_000_000;
         ms = $signed($urandom_range(0, 2_000_000)) - 1_000_000;
      end
      send_item(op, sp, ms, 1'b0, '0, 1'b0);
   endtask

   task automatic random_gains(input int mode);
      // mode 0 random, 1 max, 2 min, 3 integral off
      logic [pidc_pkg::GAIN_W-1:0] g[3];
      for (int k = 0; k < 3; k++) begin
         case (mode)
            1:       g[k] = 24'h7fffff;
            2:       g[k] = 24'h800000;
            default: g[k] = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                           : 24'($signed($urandom_range(0, 262144)) - 131072);
         endcase
      end
      if (mode == 3) g[1] = '0;
      write_reg(pidc_pkg::REG_PROP_GAIN, g[0]);
      write_reg(pidc_pkg::REG_INTEGRAL_TIME, g[1]);
      write_reg(pidc_pkg::REG_DERIV_GAIN, g[2]);
   endtask

   // stimulus
   initial begin
      stim_row_type rows[$];
      kp = '0; ti = '0; kd = '0; err_sum = '0; prev_err = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset all gains are zero: drive is zero, only error saturation flags
      rows.push_back('{pidc_pkg::OP_STEP, 32'sh7fffffff, 32'sh80000000, 1, 0, 1});
      rows.push_back('{pidc_pkg::OP_STEP, 32'sh80000000, 32'sh7fffffff, 1, 0, 1});
      rows.push_back('{pidc_pkg::OP_STEP, 32'sh00010000, 32'sh00000000, 1, 0, 0});
      rows.push_back('{pidc_pkg::OP_CLEAR, 32'sh7fffffff, 32'sh7fffffff, 1, 0, 0});
      rows.push_back('{pidc_pkg::OP_STEP, 0, 0, 1, 0, 0});
      foreach (rows[k]) send_item(rows[k].op, rows[k].sp, rows[k].meas,
                                  rows[k].known, rows[k].drv, rows[k].sat);
      idle_gap(1);
      wait_drained();

      // unity gains, then extremes, checked by the predictor
      write_reg(pidc_pkg::REG_PROP_GAIN, 24'h010000);
      write_reg(pidc_pkg::REG_INTEGRAL_TIME, 24'h010000);
      write_reg(pidc_pkg::REG_DERIV_GAIN, 24'h010000);
      rows.delete();
      rows.push_back('{pidc_pkg::OP_STEP, 32'sh00020000, 32'sh00010000, 0, 0, 0});
      rows.push_back('{pidc_pkg::OP_STEP, 32'sh7fffffff, 32'sh80000000, 0, 0, 0});
      rows.push_back('{pidc_pkg::OP_STEP, 32'sh80000000, 32'sh7fffffff, 0, 0, 0});
      rows.push_back('{pidc_pkg::OP_STEP, 32'sh00000000, 32'sh00000001, 0, 0, 0});
      rows.push_back('{pidc_pkg::OP_CLEAR, 0, 0, 1, 0, 0});
      rows.push_back('{pidc_pkg::OP_STEP, 32'sh12345678, 32'shedcba987, 0, 0, 0});
      foreach (rows[k]) send_item(rows[k].op, rows[k].sp, rows[k].meas,
                                  rows[k].known, rows[k].drv, rows[k].sat);
      idle_gap(1);
      wait_drained();

      // tiny integral time drives the integral term to its clamp
      write_reg(pidc_pkg::REG_INTEGRAL_TIME, 24'h000001);
      for (int k = 0; k < 12; k++)
         send_item(pidc_pkg::OP_STEP, 32'sh7fffffff, 32'sh80000000, 0, 0, 0);
      for (int k = 0; k < 6; k++)
         send_item(pidc_pkg::OP_STEP, 32'sh80000000, 32'sh7fffffff, 0, 0, 0);
      idle_gap(1);
      wait_drained();
      write_reg(pidc_pkg::REG_INTEGRAL_TIME, 24'hffffff);
      send_item(pidc_pkg::OP_STEP, 32'sh00001000, 0, 0, 0, 0);
      idle_gap(1);
      wait_drained();

      // random phases in bursts with gaps; one phase under long consumer hold
      for (int ph = 0; ph < 14; ph++) begin
         random_gains(ph == 1 ? 1 : ph == 2 ? 2 : ph == 3 ? 3 : 0);
         if (ph == 4) hold_rsp = 1'b1;
         for (int k = 0; k < 120; ) begin
            int burst;
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
               send_random();
               k++;
            end
            if (ph == 4 && k > 5) hold_rsp = 1'b0;
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 90));
         end
         idle_gap(1);
         wait_drained();
      end
      stim_done = 1'b1;
   end

   // consumer stall pattern, with one long hold-off
   initial begin
      int cnt;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            cnt = 0;
            while (cnt < 600) begin
               @(negedge clock);
               cnt++;
            end
            hold_rsp = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // checker
   always @(posedge clock) begin
      drive_result_type x;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_drives.size() == 0) begin
            $error("unexpected drive item: %0d", rsp_drive);
            fail_count++;
         end else begin
            x = pending_drives.pop_front();
            if (rsp_drive !== x.drv) begin
               $error("drive: expected %0d actual %0d", x.drv, rsp_drive);
               fail_count++;
            end
            if (rsp_saturated !== x.sat) begin
               $error("saturated: expected %0d actual %0d", x.sat, rsp_saturated);
               fail_count++;
            end
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      repeat (100) @(posedge clock);
      if (pending_drives.size() != 0) begin
         $error("drive items never arrived: %0d", pending_drives.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("pid_controller_step_tb: PASS");
      else
         $display("pid_controller_step_tb: FAIL");
      $finish;
   end

endmodule

### filelist.f
sv/pidc_pkg.sv
sv/pidc_mul.sv
sv/pidc_div.sv
sv/pid_controller_step.sv
sv/pidc_check.sv
verif/pid_controller_step_tb.sv
